[rtl/stb_pkg.sv]
// shared types, codes and constants of the software timer bank
`default_nettype none

package stb_pkg;

	localparam int NUM_TIMERS_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int NEXP_W         = $clog2(MAX_RESULTS);
	localparam int MS_PER_SEC     = 1000;
	localparam int MS_W           = 10;
	localparam int SEC_W          = 32;
	localparam int TICK_W         = 16;
	localparam int QDEPTH         = 2;

	// operation codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_ALLOC   = 3'd1;
	localparam logic [2:0] OP_SET     = 3'd2;
	localparam logic [2:0] OP_REMOVE  = 3'd3;
	localparam logic [2:0] OP_ENABLE  = 3'd4;
	localparam logic [2:0] OP_DISABLE = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ERROR   = 2'd1;
	localparam logic [1:0] STAT_NO_FREE = 2'd2;

	// classified command as it waits in the queue
	typedef struct packed {
		logic [2:0]        op;
		logic              op_known;
		logic [7:0]        idx;
		logic              in_range;
		logic [TICK_W-1:0] ticks;
		logic              autor;
		logic              start;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [1:0]       status;
		logic [2:0]       index;
		logic             expired;
		logic             last;
		logic [MS_W-1:0]  ms;
		logic [SEC_W-1:0] sec;
	} res_t;

endpackage

`default_nettype wire

[rtl/software_timer_bank_top.sv]
// top level of the software timer bank
`default_nettype none

// Bank of NUM_TIMERS countdown timers with a running millisecond/seconds clock.
// Each input word carries one operation in s_tuser: tick, allocate, set, remove,
// enable or disable. Words are classified by a front end and wait in a two-entry
// command queue, so the input keeps flowing, until the queue is full, while the
// back end works or while a result word waits on m_tready. Allocate, set, remove,
// enable and disable each give one result word from the back end. A tick leaves
// the queue, then the decrement state decrements the enabled timers and advances
// the clock, then the scan state checks the slots one per cycle while m_tready
// does not hold a result word back, giving one word per expired timer in index
// order (at most eight per tick; the rest are reported on a later tick), or one
// word with the expired flag clear if none expired. m_tlast marks the final word
// caused by one input word. The clock wraps milliseconds at 1000 and seconds
// modulo 2^32.

module software_timer_bank_top #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] timer_index, [23:8] tick_count, [24] auto_reload, [25] start_enabled,
	// [31:26] zero
	input  wire logic [31:0] s_tdata,
	// [2:0] operation
	input  wire logic [2:0]  s_tuser,
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [4:2] result_index, [14:5] milliseconds, [46:15] seconds,
	// [47] zero
	output logic [47:0]      m_tdata,
	// [0] expired
	output logic             m_tuser,
	output logic             m_tlast
);
	import stb_pkg::*;

	cmd_t push_cmd;
	cmd_t q_cmd;
	res_t res;
	logic push;
	logic q_full;
	logic q_valid;
	logic pop;

	// classify incoming words
	stb_front #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	// decouples the front end from the slot scan
	stb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	// timer slots, clock and result register
	stb_back #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// pack the result word
	assign m_tdata = {1'b0, res.sec, res.ms, res.index, res.status};
	assign m_tuser = res.expired;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

[rtl/stb_front.sv]
// front end: accepts input words and classifies them into commands
`default_nettype none

module stb_front #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        q_full,
	output logic             push,
	output stb_pkg::cmd_t    cmd
);
	import stb_pkg::*;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		cmd.op       = s_tuser;
		cmd.op_known = (s_tuser inside {OP_TICK, OP_ALLOC, OP_SET, OP_REMOVE, OP_ENABLE,
			OP_DISABLE});
		cmd.idx      = s_tdata[7:0];
		cmd.in_range = {1'b0, s_tdata[7:0]} < 9'(NUM_TIMERS);
		cmd.ticks    = s_tdata[23:8];
		cmd.autor    = s_tdata[24];
		cmd.start    = s_tdata[25];
	end

endmodule

`default_nettype wire

[rtl/stb_queue.sv]
// short command queue between front end and execution back end
`default_nettype none

module stb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire stb_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               q_valid,
	output stb_pkg::cmd_t      q_cmd
);
	import stb_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(QDEPTH);
	assign q_valid = count_q != '0;
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/stb_back.sv]
// back end: timer slots, running clock, tick scan and result register
`default_nettype none

module stb_back #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire stb_pkg::cmd_t q_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output stb_pkg::res_t      out_res
);
	import stb_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] en_q;
	logic [NUM_TIMERS-1:0] auto_q;
	logic [TICK_W-1:0]     reload_q [NUM_TIMERS];
	logic [TICK_W-1:0]     count_q  [NUM_TIMERS];
	logic [MS_W-1:0]       ms_q;
	logic [SEC_W-1:0]      sec_q;
	logic [1:0]            state_q;
	logic [IDX_W-1:0]      scan_q;
	logic [NEXP_W-1:0]     nexp_q;
	logic                  out_valid_q;
	res_t                  out_q;

	logic [NUM_TIMERS-1:0] flag;
	logic [NUM_TIMERS-1:0] reload_nz;
	logic [NUM_TIMERS-1:0] above;
	logic                  any_above;
	logic                  hit;
	logic                  free_found;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      cmd_slot;
	logic                  out_free;
	logic                  exec;
	logic                  scan_step;
	logic                  emit_last;
	logic                  load;
	res_t                  load_res;
	logic [7:0]            scan_wide;
	logic [7:0]            free_wide;

	assign cmd_slot  = q_cmd.idx[IDX_W-1:0];
	assign out_free  = !out_valid_q || out_ready;
	assign scan_wide = 8'(scan_q);
	assign free_wide = 8'(free_idx);

	// per-slot expiry flags and first free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			flag[i]      = en_q[i] && (count_q[i] == '0);
			reload_nz[i] = reload_q[i] != '0;
			above[i]     = flag[i] && (IDX_W'(i) > scan_q);
		end
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign any_above = |above;
	assign hit       = flag[scan_q];
	assign emit_last = !any_above || (nexp_q == NEXP_W'(MAX_RESULTS - 1));

	assign exec      = (state_q == ST_IDLE) && q_valid && (q_cmd.op != OP_TICK) && out_free;
	assign pop       = (state_q == ST_IDLE) && q_valid && ((q_cmd.op == OP_TICK) || out_free);
	assign scan_step = (state_q == ST_SCAN) && out_free;

	// result of a command or a scan step
	always_comb begin
		load              = 1'b0;
		load_res.status   = STAT_OK;
		load_res.index    = 3'd0;
		load_res.expired  = 1'b0;
		load_res.last     = 1'b1;
		load_res.ms       = ms_q;
		load_res.sec      = sec_q;
		if (exec) begin
			load = 1'b1;
			case (q_cmd.op)
				OP_ALLOC: begin
					if (free_found) begin
						load_res.index = free_wide[2:0];
					end else begin
						load_res.status = STAT_NO_FREE;
					end
				end
				OP_SET: begin
					load_res.index  = q_cmd.idx[2:0];
					load_res.status = (q_cmd.in_range && valid_q[cmd_slot]) ? STAT_OK : STAT_ERROR;
				end
				OP_ENABLE: begin
					load_res.index  = q_cmd.idx[2:0];
					load_res.status = (q_cmd.in_range && reload_nz[cmd_slot]) ?
						STAT_OK : STAT_ERROR;
				end
				OP_REMOVE, OP_DISABLE: begin
					load_res.index  = q_cmd.idx[2:0];
					load_res.status = q_cmd.in_range ? STAT_OK : STAT_ERROR;
				end
				default: begin
					load_res.status = STAT_ERROR;
				end
			endcase
		end else if (scan_step) begin
			if (hit) begin
				load             = 1'b1;
				load_res.index   = scan_wide[2:0];
				load_res.expired = 1'b1;
				load_res.last    = emit_last;
			end else if (!any_above && nexp_q == '0) begin
				// tick without expiry
				load = 1'b1;
			end
		end
	end

	// slot state and clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			en_q    <= '0;
			auto_q  <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				reload_q[i] <= '0;
				count_q[i]  <= '0;
			end
			ms_q    <= '0;
			sec_q   <= '0;
			state_q <= ST_IDLE;
			scan_q  <= '0;
			nexp_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && q_cmd.op == OP_TICK) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (en_q[i] && count_q[i] != '0) begin
							count_q[i] <= count_q[i] - 1'b1;
						end
					end
					if (ms_q == MS_W'(MS_PER_SEC - 1)) begin
						ms_q  <= '0;
						sec_q <= sec_q + 1'b1;
					end else begin
						ms_q <= ms_q + 1'b1;
					end
					scan_q  <= '0;
					nexp_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_step) begin
						if (hit) begin
							for (int i = 0; i < NUM_TIMERS; i++) begin
								if (IDX_W'(i) == scan_q) begin
									if (auto_q[i]) begin
										count_q[i] <= reload_q[i];
									end else begin
										en_q[i] <= 1'b0;
									end
								end
							end
							nexp_q <= nexp_q + 1'b1;
							if (emit_last) begin
								state_q <= ST_IDLE;
							end else begin
								scan_q <= scan_q + 1'b1;
							end
						end else if (!any_above) begin
							state_q <= ST_IDLE;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (exec) begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					case (q_cmd.op)
						OP_ALLOC: begin
							if (free_found && IDX_W'(i) == free_idx) begin
								valid_q[i]  <= 1'b1;
								en_q[i]     <= 1'b0;
								auto_q[i]   <= 1'b0;
								reload_q[i] <= '0;
								count_q[i]  <= '0;
							end
						end
						OP_SET: begin
							if (q_cmd.in_range && IDX_W'(i) == cmd_slot && valid_q[i]) begin
								reload_q[i] <= q_cmd.ticks;
								count_q[i]  <= q_cmd.ticks;
								auto_q[i]   <= q_cmd.autor;
								en_q[i]     <= q_cmd.start;
							end
						end
						OP_REMOVE: begin
							if (q_cmd.in_range && IDX_W'(i) == cmd_slot) begin
								valid_q[i]  <= 1'b0;
								en_q[i]     <= 1'b0;
								reload_q[i] <= '0;
								count_q[i]  <= '0;
							end
						end
						OP_ENABLE: begin
							if (q_cmd.in_range && IDX_W'(i) == cmd_slot && reload_nz[i]) begin
								en_q[i]    <= 1'b1;
								count_q[i] <= reload_q[i];
							end
						end
						OP_DISABLE: begin
							if (q_cmd.in_range && IDX_W'(i) == cmd_slot) begin
								en_q[i] <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

`ifndef ASSERT_OFF
	a_dec_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEC |=> state_q == ST_SCAN)
		else $error("decrement step not followed by scan");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_step && hit && emit_last) |=> state_q == ST_IDLE)
		else $error("scan continued after final expiry");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q < MS_W'(MS_PER_SEC))
		else $error("millisecond count out of range");

	a_expired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.expired) |-> (out_q.status == STAT_OK))
		else $error("expiry word with non-ok status");
`endif

endmodule

`default_nettype wire
